[hw/rtl/pex_partition_tree_builder_defines.svh]
// Assertion macros for the partition tree builder RTL.
`ifndef PEX_PARTITION_TREE_BUILDER_DEFINES_SVH
`define PEX_PARTITION_TREE_BUILDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define PEX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pex_partition_tree_builder: same-cycle check failed");

`define PEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pex_partition_tree_builder: next-cycle check failed");

`else

`define PEX_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define PEX_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/pex_ptb_pkg.sv]
// Shared constants for the partition tree builder.
package pex_ptb_pkg;

    localparam int PEX_ERR_W        = 5;
    localparam int PEX_IDX_W        = 5;
    localparam int PEX_MAX_ERRORS   = 31;
    localparam int PEX_LENGTH_BITS  = 16;
    localparam int PEX_STACK_DEPTH  = 8;
    localparam int PEX_MAX_RESULTS  = 63;
    localparam int PEX_CNT_W        = 6;

endpackage

[hw/rtl/pex_partition_tree_builder.sv]
// Top level: builds the partition tree of one query and streams its nodes.
//
//  channel  dir  fields (tdata/tuser from bit 0 up)
//  s_axis   in   tdata: query_length, error_budget
//  m_axis   out  tdata: has_parent, parent_index, range_start, range_end, node_errors
//                tuser: is_leaf, bad_request; tlast: last
//
// Per query: the leaf length divider runs first, then the walk emits the nodes, passing
// through a pop state for each node taken back from the stack (stack RAM read latency).
// A rejected query skips the divider. The stack RAM needs no clearing after reset.
// Output backpressure stalls the walk.
module pex_partition_tree_builder
    import pex_ptb_pkg::*;
#(
    parameter int MAX_ERRORS  = PEX_MAX_ERRORS,
    parameter int LENGTH_BITS = PEX_LENGTH_BITS,
    parameter int STACK_DEPTH = PEX_STACK_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // query_length, error_budget, zero pad
    input  logic [((LENGTH_BITS+PEX_ERR_W+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // has_parent, parent_index, range_start, range_end, node_errors, zero pad
    output logic [((2*LENGTH_BITS+PEX_ERR_W+PEX_IDX_W+1+7)/8)*8-1:0] o_m_axis_tdata,
    // is_leaf, bad_request
    output logic [1:0]              o_m_axis_tuser,
    output logic                    o_m_axis_tlast
);

    `include "pex_partition_tree_builder_defines.svh"

    localparam int LB      = LENGTH_BITS;
    localparam int OUT_RAW = 2*LB + PEX_ERR_W + PEX_IDX_W + 1;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int STK_W   = 2*LB + PEX_ERR_W + PEX_IDX_W;
    localparam int AW      = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_POP  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [LB-1:0]        r_len, n_len;
    logic                 r_bad, n_bad;
    logic [LB-1:0]        r_leaf_len, n_leaf_len;
    logic [LB-1:0]        r_cur_start, n_cur_start;
    logic [LB-1:0]        r_cur_end, n_cur_end;
    logic [PEX_ERR_W-1:0] r_cur_err, n_cur_err;
    logic [PEX_IDX_W-1:0] r_cur_parent, n_cur_parent;
    logic                 r_cur_hp, n_cur_hp;
    logic [SP_W-1:0]      r_sp, n_sp;
    logic [PEX_IDX_W-1:0] r_inner, n_inner;
    logic [PEX_CNT_W-1:0] r_count, n_count;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_W-1:0]     r_out_data, n_out_data;
    logic [1:0]           r_out_user, n_out_user;
    logic                 r_out_last, n_out_last;

    logic                 w_accept;
    logic [LB-1:0]        w_in_len;
    logic [PEX_ERR_W-1:0] w_in_k, w_k_sat;
    logic                 w_in_bad;
    logic                 w_div_start, w_div_done;
    logic [LB-1:0]        w_quotient;
    logic                 w_out_free;
    logic                 w_leaf, w_last;
    logic [PEX_ERR_W-1:0] w_left;
    logic [LB+PEX_ERR_W-1:0] w_prod;
    logic [LB-1:0]        w_split;
    logic [PEX_ERR_W-1:0] w_right_err;
    logic [PEX_ERR_W:0]   w_err_inc;
    logic                 w_wr_en, w_rd_en;
    logic [AW-1:0]        w_wr_addr, w_rd_addr;
    logic [STK_W-1:0]     w_wr_data, w_rd_data;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_len = i_s_axis_tdata[LB-1:0];
    assign w_in_k   = i_s_axis_tdata[LB+PEX_ERR_W-1:LB];
    assign w_k_sat  = (w_in_k > PEX_ERR_W'(MAX_ERRORS)) ? PEX_ERR_W'(MAX_ERRORS) : w_in_k;
    assign w_in_bad = ((LB+1)'(w_in_len) < ((LB+1)'(w_k_sat) + (LB+1)'(1)));
    assign w_div_start = w_accept && !w_in_bad;

    pex_ptb_div #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_in_len),
        .i_divisor  ((PEX_ERR_W+1)'(w_k_sat) + (PEX_ERR_W+1)'(1)),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_leaf     = (r_cur_err == '0);
    assign w_last     = (w_leaf && (r_sp == '0)) ||
                        (r_count == PEX_CNT_W'(PEX_MAX_RESULTS - 1));

    // left leaves = e/2 + 1; left child gets e/2, right child gets ceil(e/2) - 1
    assign w_left      = PEX_ERR_W'(r_cur_err >> 1) + PEX_ERR_W'(1);
    assign w_prod      = (LB+PEX_ERR_W)'(r_leaf_len) * (LB+PEX_ERR_W)'(w_left);
    assign w_split     = r_cur_start + w_prod[LB-1:0];
    assign w_err_inc   = (PEX_ERR_W+1)'(r_cur_err) + (PEX_ERR_W+1)'(1);
    assign w_right_err = PEX_ERR_W'(w_err_inc >> 1) - PEX_ERR_W'(1);

    assign w_wr_addr = r_sp[AW-1:0];
    assign w_wr_data = {r_inner, w_right_err, r_cur_end, w_split};
    assign w_rd_addr = AW'(r_sp - SP_W'(1));

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_bad        = r_bad;
        n_leaf_len   = r_leaf_len;
        n_cur_start  = r_cur_start;
        n_cur_end    = r_cur_end;
        n_cur_err    = r_cur_err;
        n_cur_parent = r_cur_parent;
        n_cur_hp     = r_cur_hp;
        n_sp         = r_sp;
        n_inner      = r_inner;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_out_last   = r_out_last;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_len     = w_in_len;
                    n_bad     = w_in_bad;
                    n_cur_err = w_k_sat;
                    n_state   = w_in_bad ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_leaf_len   = w_quotient;
                    n_cur_start  = '0;
                    n_cur_end    = r_len - LB'(1);
                    n_cur_parent = '0;
                    n_cur_hp     = 1'b0;
                    n_sp         = '0;
                    n_inner      = '0;
                    n_count      = '0;
                    n_state      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_bad) begin
                        n_out_data = '0;
                        n_out_user = 2'b10;
                        n_out_last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_out_data = OUT_W'({r_cur_err, r_cur_end, r_cur_start,
                                             r_cur_parent, r_cur_hp});
                        n_out_user = {1'b0, w_leaf};
                        n_out_last = w_last;
                        n_count    = r_count + PEX_CNT_W'(1);
                        if (w_last) begin
                            n_sp    = '0;
                            n_state = ST_IDLE;
                        end else if (w_leaf) begin
                            w_rd_en = 1'b1;
                            n_sp    = r_sp - SP_W'(1);
                            n_state = ST_POP;
                        end else begin
                            if (r_sp < SP_W'(STACK_DEPTH)) begin
                                w_wr_en = 1'b1;
                                n_sp    = r_sp + SP_W'(1);
                            end
                            n_cur_end    = w_split - LB'(1);
                            n_cur_err    = PEX_ERR_W'(r_cur_err >> 1);
                            n_cur_parent = r_inner;
                            n_cur_hp     = 1'b1;
                            n_inner      = r_inner + PEX_IDX_W'(1);
                        end
                    end
                end
            end
            ST_POP: begin
                {n_cur_parent, n_cur_err, n_cur_end, n_cur_start} = w_rd_data;
                n_cur_hp = 1'b1;
                n_state  = ST_EMIT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sp        <= '0;
            r_inner     <= '0;
            r_count     <= '0;
            r_leaf_len  <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_inner     <= n_inner;
            r_count     <= n_count;
            r_leaf_len  <= n_leaf_len;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
        r_len        <= n_len;
        r_cur_start  <= n_cur_start;
        r_cur_end    <= n_cur_end;
        r_cur_err    <= n_cur_err;
        r_cur_parent <= n_cur_parent;
        r_cur_hp     <= n_cur_hp;
        r_out_data   <= n_out_data;
        r_out_user   <= n_out_user;
        r_out_last   <= n_out_last;
    end

    // pending right children; push and pop never hit the same entry in one cycle
    pex_ptb_ram #(
        .WIDTH(STK_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    `PEX_ASSERT_IMPL(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= SP_W'(STACK_DEPTH))
    `PEX_ASSERT_IMPL(a_bad_is_last, i_clk, i_rst_n, r_out_valid && r_out_user[1], r_out_last)
    `PEX_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_rd_en, r_sp != '0)
    `PEX_ASSERT_NEXT(a_pop_to_emit, i_clk, i_rst_n, r_state == ST_POP, r_state == ST_EMIT)
    `PEX_ASSERT_IMPL(a_div_in_div, i_clk, i_rst_n, w_div_done, r_state == ST_DIV)

endmodule

[hw/rtl/pex_ptb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pex_ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/pex_ptb_div.sv]
// Restoring divider, one quotient bit per cycle: length / (budget + 1).
module pex_ptb_div
    import pex_ptb_pkg::*;
#(
    parameter int LENGTH_BITS = PEX_LENGTH_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [LENGTH_BITS-1:0] i_dividend,
    input  logic [PEX_ERR_W:0]     i_divisor,
    output logic                   o_done,
    output logic [LENGTH_BITS-1:0] o_quotient
);

    localparam int CNT_W = $clog2(LENGTH_BITS);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [PEX_ERR_W-1:0]   r_rem, n_rem;
    logic [LENGTH_BITS-1:0] r_quo, n_quo;
    logic [PEX_ERR_W:0]     r_div, n_div;
    logic [PEX_ERR_W:0]     w_trial;
    logic                   w_ge;

    assign w_trial = {r_rem, r_quo[LENGTH_BITS-1]};
    assign w_ge    = (w_trial >= r_div);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(LENGTH_BITS - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? PEX_ERR_W'(w_trial - r_div) : w_trial[PEX_ERR_W-1:0];
            n_quo = {r_quo[LENGTH_BITS-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the partition tree builder: streams queries, predicts every node.
module testbench;
    import pex_ptb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W        = ((PEX_LENGTH_BITS + PEX_ERR_W + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * PEX_LENGTH_BITS + PEX_ERR_W + PEX_IDX_W + 1 + 7) / 8) * 8;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_OFF    = 400;
    localparam int SETTLE      = 64;

    typedef struct {
        int unsigned first_pos;
        int unsigned last_pos;
        int unsigned errors;
        int unsigned parent;
        bit          has_parent;
    } tree_node_t;

    typedef struct {
        logic                       is_leaf;
        logic                       has_parent;
        logic [PEX_IDX_W-1:0]       parent_index;
        logic [PEX_LENGTH_BITS-1:0] range_start;
        logic [PEX_LENGTH_BITS-1:0] range_end;
        logic [PEX_ERR_W-1:0]       node_errors;
        logic                       bad_request;
        logic                       last;
    } node_result_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // query_length, error_budget, zero pad
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // has_parent, parent_index, range_start, range_end, node_errors, zero pad
    logic [OUT_W-1:0] m_tdata;
    // is_leaf, bad_request
    logic [1:0]       m_tuser;
    logic             m_tlast;

    node_result_t expected_nodes[$];
    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    int           burst_left = 0;
    int           rx_mode = 0;
    int           rx_hold_req = 0;
    int           rx_hold_cnt = 0;
    int           rx_age = 0;
    logic [15:0]  rx_pattern = 16'hffff;

    pex_partition_tree_builder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Expected node list of one query, in depth-first preorder.
    function automatic void predict_partition_tree(input logic [PEX_LENGTH_BITS-1:0] qlen,
                                                   input logic [PEX_ERR_W-1:0] budget);
        tree_node_t   pend[PEX_STACK_DEPTH];
        tree_node_t   cur;
        tree_node_t   right;
        node_result_t held;
        int unsigned  k;
        int unsigned  leaf_len;
        int unsigned  e;
        int unsigned  left;
        int unsigned  split;
        int unsigned  inner;
        int           sp;
        int           n;
        bit           more;
        bit           held_valid;
        k = budget;
        if (k > PEX_MAX_ERRORS) begin
            k = PEX_MAX_ERRORS;
        end
        held = '{default: '0};
        if (qlen < k + 1) begin
            held.bad_request = 1'b1;
            held.last = 1'b1;
            expected_nodes.insert(expected_nodes.size(), held);
            return;
        end
        leaf_len = qlen / (k + 1);
        cur.first_pos = 0;
        cur.last_pos = qlen - 1;
        cur.errors = k;
        cur.parent = 0;
        cur.has_parent = 1'b0;
        inner = 0;
        sp = 0;
        n = 0;
        more = 1'b1;
        held_valid = 1'b0;
        while (more && n < PEX_MAX_RESULTS) begin
            if (held_valid) begin
                expected_nodes.insert(expected_nodes.size(), held);
            end
            held.is_leaf = (cur.errors == 0);
            held.has_parent = cur.has_parent;
            held.parent_index = cur.parent[PEX_IDX_W-1:0];
            held.range_start = cur.first_pos[PEX_LENGTH_BITS-1:0];
            held.range_end = cur.last_pos[PEX_LENGTH_BITS-1:0];
            held.node_errors = cur.errors[PEX_ERR_W-1:0];
            held.bad_request = 1'b0;
            held.last = 1'b0;
            held_valid = 1'b1;
            n++;
            if (cur.errors == 0) begin
                if (sp > 0) begin
                    sp--;
                    cur = pend[sp];
                end else begin
                    more = 1'b0;
                end
            end else begin
                e = cur.errors;
                left = (e + 2) / 2;
                split = cur.first_pos + left * leaf_len;
                right.first_pos = split;
                right.last_pos = cur.last_pos;
                right.errors = ((e + 1 - left) * e) / (e + 1);
                right.parent = inner;
                right.has_parent = 1'b1;
                // full stack drops the right subtree
                if (sp < PEX_STACK_DEPTH) begin
                    pend[sp] = right;
                    sp++;
                end
                cur.last_pos = split - 1;
                cur.errors = (left * e) / (e + 1);
                cur.parent = inner;
                cur.has_parent = 1'b1;
                inner = (inner + 1) % (1 << PEX_IDX_W);
            end
        end
        held.last = 1'b1;
        expected_nodes.insert(expected_nodes.size(), held);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance, tvalid still high.
    task automatic send_query(input logic [PEX_LENGTH_BITS-1:0] qlen,
                              input logic [PEX_ERR_W-1:0] budget);
        s_tdata <= IN_W'({budget, qlen});
        s_tvalid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        predict_partition_tree(qlen, budget);
        @(negedge i_clk);
    endtask

    task automatic sender_idle(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Burst/gap pacing between transactions
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            sender_idle($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) :
                                                       $urandom_range(0, 5);
        end
    endtask

    task automatic send_paced(input logic [PEX_LENGTH_BITS-1:0] qlen,
                              input logic [PEX_ERR_W-1:0] budget);
        send_query(qlen, budget);
        pace_sender();
    endtask

    task automatic wait_drained();
        while (expected_nodes.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic test_rejected_queries();
        send_paced(16'd0, 5'd0);
        send_paced(16'd0, 5'd31);
        send_paced(16'd31, 5'd31);
        send_paced(16'd3, 5'd4);
        send_paced(16'd1, 5'd1);
    endtask

    task automatic test_directed_trees();
        send_paced(16'd1, 5'd0);
        send_paced(16'hffff, 5'd0);
        send_paced(16'd2, 5'd1);
        send_paced(16'd3, 5'd2);
        send_paced(16'd5, 5'd4);
        send_paced(16'd32, 5'd31);
        send_paced(16'hffff, 5'd31);
        send_paced(16'd100, 5'd3);
        send_paced(16'd1000, 5'd7);
        send_paced(16'haaaa, 5'd21);
        send_paced(16'h5555, 5'd10);
        send_paced(16'd4097, 5'd16);
        send_paced(16'd40, 5'd15);
    endtask

    task automatic test_random_queries(input int count);
        logic [PEX_LENGTH_BITS-1:0] qlen;
        logic [PEX_ERR_W-1:0]       budget;
        int                         pick;
        for (int i = 0; i < count; i++) begin
            if (i % 30 == 0) begin
                rx_mode = $urandom_range(0, 2) == 0 ? 0 : 1;
            end
            pick = $urandom_range(0, 3);
            budget = (pick == 0) ? 5'd31 : 5'($urandom_range(0, 31));
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                qlen = PEX_LENGTH_BITS'($urandom_range(0, budget));
            end else if (pick < 4) begin
                qlen = PEX_LENGTH_BITS'(budget + 1 + $urandom_range(0, 64));
            end else if (pick == 4) begin
                qlen = PEX_LENGTH_BITS'(budget + 1);
            end else begin
                qlen = PEX_LENGTH_BITS'($urandom_range(budget + 1, 16'hffff));
            end
            send_paced(qlen, budget);
        end
    endtask

    task automatic test_output_hold_off();
        rx_hold_req = HOLD_OFF;
        for (int i = 0; i < 8; i++) begin
            send_query(PEX_LENGTH_BITS'($urandom_range(32, 16'hffff)), 5'd31);
        end
        burst_left = 0;
        pace_sender();
    endtask

    task automatic test_drain_pause();
        rx_mode = 1;
        send_query(16'd777, 5'd9);
        send_query(16'd12, 5'd11);
        sender_idle(0);
        wait_drained();
        send_paced(16'd60000, 5'd30);
        send_paced(16'd6, 5'd2);
    endtask

    // Receiver: long hold-offs on request, else always ready or a rotating pattern.
    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_cnt = rx_hold_req;
            rx_hold_req = 0;
        end
        rx_age++;
        if (rx_age >= 48) begin
            rx_age = 0;
            rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
        end
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            m_tready <= 1'b0;
        end else if (rx_mode == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= rx_pattern[0];
        end
    end

    always @(posedge i_clk) begin
        node_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_nodes.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[31:0], 32'd0);
            end else begin
                want = expected_nodes.pop_front();
                if (m_tuser[0] !== want.is_leaf)
                    report_mismatch("is_leaf", m_tuser[0], want.is_leaf);
                if (m_tdata[0] !== want.has_parent)
                    report_mismatch("has_parent", m_tdata[0], want.has_parent);
                if (m_tdata[5:1] !== want.parent_index)
                    report_mismatch("parent_index", m_tdata[5:1], want.parent_index);
                if (m_tdata[21:6] !== want.range_start)
                    report_mismatch("range_start", m_tdata[21:6], want.range_start);
                if (m_tdata[37:22] !== want.range_end)
                    report_mismatch("range_end", m_tdata[37:22], want.range_end);
                if (m_tdata[42:38] !== want.node_errors)
                    report_mismatch("node_errors", m_tdata[42:38], want.node_errors);
                if (m_tuser[1] !== want.bad_request)
                    report_mismatch("bad_request", m_tuser[1], want.bad_request);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        rx_mode = 1;
        test_rejected_queries();
        test_directed_trees();
        test_output_hold_off();
        test_drain_pause();
        test_random_queries(120);
        sender_idle(0);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && expected_nodes.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
